FILE: sv/rgb_channel_gain_keyed_blend_assert.svh
// ----------------------------------------------------------------------------
// RGB channel gain assertion macros
// Shared concurrent assertion wrappers, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef RGB_CHANNEL_GAIN_KEYED_BLEND_ASSERT_SVH
`define RGB_CHANNEL_GAIN_KEYED_BLEND_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define RGBG_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rgbgain: implication check failed");
// Next-cycle implication.
`define RGBG_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rgbgain: next-cycle check failed");
`else
`define RGBG_ASSERT_IMP(lbl, ante, cons)
`define RGBG_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: sv/rgbgain_pkg.sv
// ----------------------------------------------------------------------------
// RGB channel gain package
// Shared types, register map codes and gain helper functions.
// ----------------------------------------------------------------------------
package rgbgain_pkg;

   localparam int ADDR_W = 5;
   localparam int MULT_W = 22;
   localparam int PROD_W = 30;

   // Register indexes (byte address divided by four).
   localparam logic [2:0] REG_ENABLE       = 3'd0;
   localparam logic [2:0] REG_BLEND_MODE   = 3'd1;
   localparam logic [2:0] REG_KEY_EXCLUDE  = 3'd2;
   localparam logic [2:0] REG_RED_GAIN     = 3'd3;
   localparam logic [2:0] REG_GREEN_GAIN   = 3'd4;
   localparam logic [2:0] REG_BLUE_GAIN    = 3'd5;
   localparam logic [2:0] REG_KEY_COLOR    = 3'd6;
   localparam logic [2:0] REG_KEY_DISTANCE = 3'd7;

   // Blend modes; the unused code behaves as the saturating add.
   localparam logic [1:0] BLEND_REPLACE = 2'd0;
   localparam logic [1:0] BLEND_AVERAGE = 2'd1;
   localparam logic [1:0] BLEND_ADD     = 2'd2;

   typedef struct packed {
      logic              enable;
      logic [1:0]        blend_mode;
      logic              key_exclude;
      logic signed [13:0] red_gain;
      logic signed [13:0] green_gain;
      logic signed [13:0] blue_gain;
      logic [23:0]       key_color;
      logic [7:0]        key_distance;
   } cfg_type;

   // Q16 multiplier for one gain setting. A negative multiplier is
   // returned as zero, which makes the scaled channel zero as well.
   function automatic logic [MULT_W-1:0] gain_to_mult(input logic signed [13:0] g);
      logic signed [23:0] gx;
      logic signed [23:0] m;
      gx = {{10{g[13]}}, g};
      if (g[13]) begin
         m = 24'sd65536 + (gx <<< 4);
      end else begin
         m = 24'sd65536 + (gx <<< 8);
      end
      if (m[23]) begin
         return '0;
      end
      return m[MULT_W-1:0];
   endfunction

   // True when two channel values differ by no more than the distance.
   function automatic logic chan_near(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] d);
      logic [7:0] diff;
      diff = (a > b) ? (a - b) : (b - a);
      return diff <= d;
   endfunction

   // Scaled channel from a product: shift out the Q16 fraction, clamp at 255.
   function automatic logic [7:0] prod_to_chan(input logic [PROD_W-1:0] p);
      logic [13:0] whole;
      whole = p[PROD_W-1:16];
      return (whole > 14'd255) ? 8'hFF : whole[7:0];
   endfunction

   // Combine original and scaled channel according to the blend mode.
   function automatic logic [7:0] blend_chan(input logic [1:0] mode, input logic [7:0] o,
                                             input logic [7:0] s);
      logic [8:0] sum;
      logic [7:0] res;
      sum = {1'b0, o} + {1'b0, s};
      case (mode)
         BLEND_REPLACE: res = s;
         BLEND_AVERAGE: res = {1'b0, o[7:1]} + {1'b0, s[7:1]};
         default:       res = sum[8] ? 8'hFF : sum[7:0];
      endcase
      return res;
   endfunction

endpackage

FILE: sv/rgbgain_csr.sv
// ----------------------------------------------------------------------------
// RGB channel gain register file
// APB-style register bank holding the gain, blend and color key settings.
// ----------------------------------------------------------------------------
module rgbgain_csr import rgbgain_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready,
   output cfg_type           cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite & pready;
   assign reg_idx = paddr[ADDR_W-1:2];
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_ENABLE:       cfg_in.enable       = pwdata[0];
            REG_BLEND_MODE:   cfg_in.blend_mode   = pwdata[1:0];
            REG_KEY_EXCLUDE:  cfg_in.key_exclude  = pwdata[0];
            REG_RED_GAIN:     cfg_in.red_gain     = pwdata[13:0];
            REG_GREEN_GAIN:   cfg_in.green_gain   = pwdata[13:0];
            REG_BLUE_GAIN:    cfg_in.blue_gain    = pwdata[13:0];
            REG_KEY_COLOR:    cfg_in.key_color    = pwdata[23:0];
            REG_KEY_DISTANCE: cfg_in.key_distance = pwdata[7:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable       <= 1'b1;
         cfg_ff.blend_mode   <= BLEND_AVERAGE;
         cfg_ff.key_exclude  <= 1'b0;
         cfg_ff.red_gain     <= '0;
         cfg_ff.green_gain   <= '0;
         cfg_ff.blue_gain    <= '0;
         cfg_ff.key_color    <= '0;
         cfg_ff.key_distance <= 8'd16;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Gains read back sign extended.
   always_comb begin
      case (reg_idx)
         REG_ENABLE:       prdata = {31'd0, cfg_ff.enable};
         REG_BLEND_MODE:   prdata = {30'd0, cfg_ff.blend_mode};
         REG_KEY_EXCLUDE:  prdata = {31'd0, cfg_ff.key_exclude};
         REG_RED_GAIN:     prdata = {{18{cfg_ff.red_gain[13]}}, cfg_ff.red_gain};
         REG_GREEN_GAIN:   prdata = {{18{cfg_ff.green_gain[13]}}, cfg_ff.green_gain};
         REG_BLUE_GAIN:    prdata = {{18{cfg_ff.blue_gain[13]}}, cfg_ff.blue_gain};
         REG_KEY_COLOR:    prdata = {8'd0, cfg_ff.key_color};
         REG_KEY_DISTANCE: prdata = {24'd0, cfg_ff.key_distance};
         default:          prdata = '0;
      endcase
   end

endmodule

FILE: sv/rgbgain_pipe.sv
// ----------------------------------------------------------------------------
// RGB channel gain datapath
// Three-stage pixel pipeline: key test and multiplier, product, clamp and blend.
// ----------------------------------------------------------------------------
`include "rgb_channel_gain_keyed_blend_assert.svh"

module rgbgain_pipe import rgbgain_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [23:0] req_pixel_in,
   input  logic        req_frame_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [23:0] rsp_pixel_out,
   output logic        rsp_frame_last_out
);

   // Stage 1: input pixel, bypass decision and per-channel multipliers.
   logic                   s1_valid_ff, s1_valid_in;
   logic [23:0]            s1_pixel_ff;
   logic                   s1_last_ff;
   logic                   s1_bypass_ff, s1_bypass_in;
   logic [2:0][MULT_W-1:0] s1_mult_ff, s1_mult_in;

   // Stage 2: products.
   logic                   s2_valid_ff, s2_valid_in;
   logic [23:0]            s2_pixel_ff;
   logic                   s2_last_ff;
   logic                   s2_bypass_ff;
   logic [2:0][PROD_W-1:0] s2_prod_ff, s2_prod_in;

   // Stage 3: output register.
   logic                   out_valid_ff, out_valid_in;
   logic [23:0]            out_pixel_ff, out_pixel_in;
   logic                   out_last_ff;

   logic out_rdy, s2_rdy, s1_rdy;
   logic ld1, ld2, ld3;
   logic near;

   // Each stage takes a new item when it is empty or its item moves on.
   assign out_rdy   = !out_valid_ff || !rsp_stall;
   assign s2_rdy    = !s2_valid_ff || out_rdy;
   assign s1_rdy    = !s1_valid_ff || s2_rdy;
   assign req_stall = !s1_rdy;

   assign ld1 = s1_rdy && req_valid;
   assign ld2 = s2_rdy && s1_valid_ff;
   assign ld3 = out_rdy && s2_valid_ff;

   assign s1_valid_in  = s1_rdy ? req_valid : s1_valid_ff;
   assign s2_valid_in  = s2_rdy ? s1_valid_ff : s2_valid_ff;
   assign out_valid_in = out_rdy ? s2_valid_ff : out_valid_ff;

   assign near = chan_near(req_pixel_in[23:16], cfg.key_color[23:16], cfg.key_distance)
              && chan_near(req_pixel_in[15:8], cfg.key_color[15:8], cfg.key_distance)
              && chan_near(req_pixel_in[7:0], cfg.key_color[7:0], cfg.key_distance);

   assign s1_bypass_in  = !cfg.enable || (cfg.key_exclude && near);
   assign s1_mult_in[0] = gain_to_mult(cfg.red_gain);
   assign s1_mult_in[1] = gain_to_mult(cfg.green_gain);
   assign s1_mult_in[2] = gain_to_mult(cfg.blue_gain);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s2_prod_in[i] = PROD_W'(s1_pixel_ff[(2-i)*8 +: 8]) * PROD_W'(s1_mult_ff[i]);
      end
   end

   always_comb begin
      if (s2_bypass_ff) begin
         out_pixel_in = s2_pixel_ff;
      end else begin
         for (int i = 0; i < 3; i++) begin
            out_pixel_in[(2-i)*8 +: 8] = blend_chan(cfg.blend_mode,
                                                    s2_pixel_ff[(2-i)*8 +: 8],
                                                    prod_to_chan(s2_prod_ff[i]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ld1) begin
         s1_pixel_ff  <= req_pixel_in;
         s1_last_ff   <= req_frame_last;
         s1_bypass_ff <= s1_bypass_in;
         s1_mult_ff   <= s1_mult_in;
      end
      if (ld2) begin
         s2_pixel_ff  <= s1_pixel_ff;
         s2_last_ff   <= s1_last_ff;
         s2_bypass_ff <= s1_bypass_ff;
         s2_prod_ff   <= s2_prod_in;
      end
      if (ld3) begin
         out_pixel_ff <= out_pixel_in;
         out_last_ff  <= s2_last_ff;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_pixel_out      = out_pixel_ff;
   assign rsp_frame_last_out = out_last_ff;

   // The input is only held off while the first stage holds an item.
   `RGBG_ASSERT_IMP(a_stall_only_when_full, req_stall, s1_valid_ff)
   // A product stage item that cannot move stays put, data and all.
   `RGBG_ASSERT_NXT(a_s2_holds, (s2_valid_ff && !ld3), (s2_valid_ff && $stable(s2_pixel_ff) && $stable(s2_prod_ff)))
   // A bypassed pixel leaves exactly as it came in.
   `RGBG_ASSERT_NXT(a_bypass_unchanged, (ld3 && s2_bypass_ff), (rsp_pixel_out == $past(s2_pixel_ff)))

endmodule

FILE: sv/rgb_channel_gain_keyed_blend.sv
// ----------------------------------------------------------------------------
// RGB channel gain with keyed blend
// Per-channel brightness gain on 24-bit RGB pixels, blended with the input.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Payload
//   req       in         req_valid/req_stall  req_pixel_in, req_frame_last
//   rsp       out        rsp_valid/rsp_stall  rsp_pixel_out, rsp_frame_last_out
//   config    in/out     psel/penable/pready  paddr, pwdata, prdata
//
// One item enters every cycle while req_stall is low; each item passes from
// acceptance through the three pipeline registers around the multiplier.
// Reset clears every stage valid bit and loads the register reset values.
// A stall on the result side fills the pipeline from the output backward, so
// up to three items are held before req_stall rises; nothing is dropped.
//
module rgb_channel_gain_keyed_blend import rgbgain_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   // Input pixel channel.
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [23:0]       req_pixel_in,
   input  logic              req_frame_last,
   // Result pixel channel.
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [23:0]       rsp_pixel_out,
   output logic              rsp_frame_last_out,
   // Register port.
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   // Current settings from the register file, read by the first and output stages.
   // They must only change while no item is in flight; the block does not enforce it.
   cfg_type cfg;

   rgbgain_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // The pixel pipeline: the first stage decides whether the item bypasses
   // the effect and turns each gain into a Q16 multiplier, the second forms
   // the three products, and the third clamps, blends and holds the result.
   rgbgain_pipe u_pipe (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_pixel_in       (req_pixel_in),
      .req_frame_last     (req_frame_last),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_pixel_out      (rsp_pixel_out),
      .rsp_frame_last_out (rsp_frame_last_out)
   );

endmodule
